/* design/mccm_pkg.sv */
package mccm_pkg;

    // fixed field widths
    localparam int VOLT_W     = 24;
    localparam int DIFF_W     = VOLT_W + 1;
    localparam int CUR_W      = 32;
    localparam int CFG_W      = 23;
    localparam int ACC_W      = 16;
    localparam int CFG_ADDR_W = 3;

    // decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // vds / 100 as multiply by reciprocal, exact for |vds| < 2^24
    localparam int DIV100_MUL_W = 25;
    localparam int DIV100_MUL   = 21474837;
    localparam int DIV100_SHIFT = 31;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_P_CHANNEL   = 3'd0,
        CFG_GATE_OFFSET = 3'd1,
        CFG_INV_RESIST  = 3'd2,
        CFG_INV_K_RDSON = 3'd3,
        CFG_ACCURACY    = 3'd4
    } t_cfg_addr;

    typedef struct packed {
        logic             p_channel;
        logic [CFG_W-1:0] gate_offset;
        logic [CFG_W-1:0] inv_resist;
        logic [CFG_W-1:0] inv_k_rdson;
        logic [ACC_W-1:0] accuracy;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        p_channel:   1'b0,
        gate_offset: 23'd147456,
        inv_resist:  23'd65536,
        inv_k_rdson: 23'd9362,
        accuracy:    16'd66
    };

    // classified request handed from front to back
    typedef struct packed {
        logic signed [DIFF_W-1:0] vds;
        logic [VOLT_W-1:0]        ov;
        logic signed [DIFF_W-1:0] vc;
    } t_item;

endpackage

/* design/mccm_front.sv */
module mccm_front import mccm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic signed [VOLT_W-1:0] i_drain_volt,
    input  logic signed [VOLT_W-1:0] i_source_volt,
    input  logic signed [VOLT_W-1:0] i_gate_volt,
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output t_item                    o_q_item
);

    logic                     r_fv;
    logic signed [DIFF_W-1:0] r_vgs;
    logic signed [DIFF_W-1:0] r_vds;
    logic                     w_take;
    logic signed [DIFF_W:0]   w_ov_raw;
    logic [VOLT_W-1:0]        w_ov;

    assign w_take   = !r_fv || !i_q_full;
    assign o_full   = !w_take;
    assign o_q_push = r_fv && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_take) begin
            r_fv <= i_push;
        end
    end

    // polarity swap of the differences
    always_ff @(posedge i_clk) begin
        if (w_take && i_push) begin
            if (i_cfg.p_channel) begin
                r_vgs <= DIFF_W'(i_source_volt) - DIFF_W'(i_gate_volt);
                r_vds <= DIFF_W'(i_source_volt) - DIFF_W'(i_drain_volt);
            end else begin
                r_vgs <= DIFF_W'(i_gate_volt) - DIFF_W'(i_source_volt);
                r_vds <= DIFF_W'(i_drain_volt) - DIFF_W'(i_source_volt);
            end
        end
    end

    // overdrive clamped at zero, vds clamped to overdrive
    always_comb begin
        w_ov_raw = (DIFF_W+1)'(r_vgs)
                 - $signed({{(DIFF_W+1-CFG_W){1'b0}}, i_cfg.gate_offset});
        w_ov     = (w_ov_raw < 0) ? '0 : w_ov_raw[VOLT_W-1:0];
        o_q_item.vds = r_vds;
        o_q_item.ov  = w_ov;
        o_q_item.vc  = (r_vds > $signed({1'b0, w_ov})) ? $signed({1'b0, w_ov}) : r_vds;
    end

endmodule

/* design/mccm_queue.sv */
module mccm_queue import mccm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wptr;
    logic [PTR_W-1:0] n_rptr;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rptr];

    assign n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

/* design/mccm_back.sv */
module mccm_back import mccm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  logic                    i_q_empty,
    input  t_item                   i_q_item,
    output logic                    o_q_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic signed [CUR_W-1:0] o_drain_current
);

    localparam int MA_W   = 32;
    localparam int MB_W   = 27;
    localparam int PROD_W = MA_W + MB_W;
    localparam int SPLIT  = 24;
    localparam int TERM_W = 2 * DIFF_W - FRAC_BITS;
    localparam int SAT_W  = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 2;
    localparam int XP_W   = TERM_W + SAT_W;
    localparam int X_W    = XP_W - FRAC_BITS;
    localparam int PP_W   = X_W + CFG_W + 1;
    localparam int PC_W   = (PP_W > 64) ? PP_W : 64;
    localparam int MC_W   = DIFF_W + CFG_W + 1 - FRAC_BITS;
    localparam int Q_W    = (DIFF_W - 1) + DIV100_MUL_W - DIV100_SHIFT;

    localparam logic signed [SAT_W-1:0] SAT_ONE  = SAT_W'(1) << FRAC_BITS;
    localparam logic signed [PC_W-1:0]  P_LIM    = {{(PC_W-63){1'b0}}, 1'b1, 62'b0};
    localparam logic signed [PC_W-1:0]  CUR_OVER = {{(PC_W-32){1'b0}}, 1'b1, 31'b0};
    localparam logic signed [PC_W-1:0]  CUR_MAX  = {{(PC_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [PC_W-1:0]  CUR_MIN  = {{(PC_W-31){1'b1}}, 31'b0};

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_M1   = 14'b00000000000010,
        S_M2   = 14'b00000000000100,
        S_M3   = 14'b00000000001000,
        S_M4   = 14'b00000000010000,
        S_M5   = 14'b00000000100000,
        S_M6   = 14'b00000001000000,
        S_X    = 14'b00000010000000,
        S_M7   = 14'b00000100000000,
        S_M8   = 14'b00001000000000,
        S_P    = 14'b00010000000000,
        S_CUR  = 14'b00100000000000,
        S_SAT  = 14'b01000000000000,
        S_CHK  = 14'b10000000000000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic signed [DIFF_W-1:0] r_vds;
    logic [VOLT_W-1:0]        r_ov;
    logic signed [DIFF_W-1:0] r_vc;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [TERM_W-1:0] r_term;
    logic signed [SAT_W-1:0]  r_sat;
    logic signed [MC_W-1:0]   r_mc;
    logic signed [X_W-1:0]    r_x;
    logic signed [PC_W-1:0]   r_p;
    logic signed [PC_W-1:0]   r_cur;
    logic signed [CUR_W-1:0]  r_c32;
    logic signed [CUR_W-1:0]  r_last;
    logic signed [CUR_W-1:0]  r_out;
    logic                     r_out_v;

    logic signed [MA_W-1:0]   w_a;
    logic signed [MB_W-1:0]   w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [DIFF_W-1:0] w_abs_vds;
    logic signed [PROD_W-1:0] w_term_raw;
    logic signed [SAT_W-1:0]  w_q;
    logic signed [XP_W-1:0]   w_xs;
    logic signed [PC_W-1:0]   w_ds;
    logic signed [PC_W-1:0]   w_d;
    logic signed [PC_W-1:0]   w_pol;
    logic signed [PC_W-1:0]   n_cur;
    logic signed [CUR_W-1:0]  n_c32;
    logic signed [CUR_W:0]    w_diff;
    logic signed [CUR_W:0]    w_acc;
    logic                     w_small;
    logic                     w_out_free;
    logic                     w_emit;

    assign o_q_pop         = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty         = !r_out_v;
    assign o_drain_current = r_out;

    assign w_abs_vds = (r_vds < 0) ? -r_vds : r_vds;

    // shared multiplier, operands picked by sequencer step
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (r_state)
            S_M1: begin
                w_a = MA_W'($signed({1'b0, r_ov}));
                w_b = MB_W'(r_vc);
            end
            S_M2: begin
                w_a = MA_W'(r_vc);
                w_b = MB_W'(r_vc);
            end
            S_M3: begin
                w_a = MA_W'(w_abs_vds);
                w_b = MB_W'($signed({1'b0, DIV100_MUL_W'(DIV100_MUL)}));
            end
            S_M4: begin
                w_a = MA_W'(r_vds);
                w_b = MB_W'($signed({1'b0, i_cfg.inv_resist}));
            end
            S_M5: begin
                w_a = MA_W'($signed({1'b0, r_term[SPLIT-1:0]}));
                w_b = MB_W'(r_sat);
            end
            S_M6: begin
                w_a = MA_W'($signed(r_term[TERM_W-1:SPLIT]));
                w_b = MB_W'(r_sat);
            end
            S_M7: begin
                w_a = MA_W'($signed({1'b0, r_x[SPLIT-1:0]}));
                w_b = MB_W'($signed({1'b0, i_cfg.inv_k_rdson}));
            end
            S_M8: begin
                w_a = MA_W'($signed(r_x[X_W-1:SPLIT]));
                w_b = MB_W'($signed({1'b0, i_cfg.inv_k_rdson}));
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    // step arithmetic on the registered product, then polarity, change filter and output slot test
    always_comb begin
        w_term_raw = r_acc - (r_prod >>> 1);
        w_q        = SAT_W'($signed({1'b0, r_prod[DIV100_SHIFT+Q_W-1:DIV100_SHIFT]}));
        w_xs       = (XP_W'(r_prod) <<< SPLIT) + XP_W'(r_acc);
        w_ds       = r_p >>> FRAC_BITS;
        w_d        = PC_W'(r_mc) - w_ds;
        w_pol      = i_cfg.p_channel ? -r_cur : r_cur;
        w_diff     = (CUR_W+1)'(r_c32) - (CUR_W+1)'(r_last);
        w_acc      = $signed({{(CUR_W+1-ACC_W){1'b0}}, i_cfg.accuracy});
        w_small    = (w_diff < w_acc) && (w_diff > -w_acc);
        w_out_free = !r_out_v || i_pop;
        w_emit     = (r_state == S_CHK) && !w_small && w_out_free;
    end

    // huge square-law term takes the current to zero or to saturation, else the difference is floored at zero
    always_comb begin
        priority if (r_p > P_LIM) begin
            n_cur = '0;
        end else if (r_p < -P_LIM) begin
            n_cur = CUR_OVER;
        end else if (w_d < 0) begin
            n_cur = '0;
        end else begin
            n_cur = w_d;
        end
    end

    always_comb begin
        priority if (w_pol > CUR_MAX) begin
            n_c32 = CUR_MAX[CUR_W-1:0];
        end else if (w_pol < CUR_MIN) begin
            n_c32 = CUR_MIN[CUR_W-1:0];
        end else begin
            n_c32 = w_pol[CUR_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  n_state = i_q_empty ? S_IDLE : S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_M3;
            S_M3:    n_state = S_M4;
            S_M4:    n_state = S_M5;
            S_M5:    n_state = S_M6;
            S_M6:    n_state = S_X;
            S_X:     n_state = S_M7;
            S_M7:    n_state = S_M8;
            S_M8:    n_state = S_P;
            S_P:     n_state = S_CUR;
            S_CUR:   n_state = S_SAT;
            S_SAT:   n_state = S_CHK;
            S_CHK:   n_state = (w_small || w_out_free) ? S_IDLE : S_CHK;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_v <= 1'b1;
                r_last  <= r_c32;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (o_q_pop) begin
            r_vds <= i_q_item.vds;
            r_ov  <= i_q_item.ov;
            r_vc  <= i_q_item.vc;
        end
        if (r_state == S_M2 || r_state == S_M6 || r_state == S_M8) begin
            r_acc <= r_prod;
        end
        if (r_state == S_M3) begin
            r_term <= TERM_W'(w_term_raw >>> FRAC_BITS);
        end
        if (r_state == S_M4) begin
            r_sat <= SAT_ONE + ((r_vds < 0) ? -w_q : w_q);
        end
        if (r_state == S_M5) begin
            r_mc <= MC_W'(r_prod >>> FRAC_BITS);
        end
        if (r_state == S_X) begin
            r_x <= X_W'(w_xs >>> FRAC_BITS);
        end
        if (r_state == S_P) begin
            r_p <= (PC_W'(r_prod) <<< SPLIT) + PC_W'(r_acc);
        end
        if (r_state == S_CUR) begin
            r_cur <= n_cur;
        end
        if (r_state == S_SAT) begin
            r_c32 <= n_c32;
        end
        if (w_emit) begin
            r_out <= r_c32;
        end
    end

endmodule

/* design/mosfet_channel_current_model_top.sv */
// path: a request passes the front register, the queue and the back-end sequencer into the output register
// throughput: the back end takes one request at a time, its sequencer running
//   eight products through a single shared multiplier
// front stage and a two-entry queue take up to three requests while the back end is busy
// reset: synchronous active-low; empties front, queue and output, clears the
//   last emitted current to zero and loads the register defaults
module mosfet_channel_current_model_top import mccm_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [CFG_W-1:0]         i_cfg_wdata,
    // request side
    input  logic                     i_push,
    output logic                     o_full,
    input  logic signed [VOLT_W-1:0] i_drain_volt,
    input  logic signed [VOLT_W-1:0] i_source_volt,
    input  logic signed [VOLT_W-1:0] i_gate_volt,
    // result side
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic signed [CUR_W-1:0]  o_drain_current
);

    t_cfg  r_cfg;
    logic  w_q_push;
    logic  w_q_full;
    logic  w_q_pop;
    logic  w_q_empty;
    t_item w_q_in;
    t_item w_q_out;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_P_CHANNEL:   r_cfg.p_channel   <= i_cfg_wdata[0];
                CFG_GATE_OFFSET: r_cfg.gate_offset <= i_cfg_wdata;
                CFG_INV_RESIST:  r_cfg.inv_resist  <= i_cfg_wdata;
                CFG_INV_K_RDSON: r_cfg.inv_k_rdson <= i_cfg_wdata;
                CFG_ACCURACY:    r_cfg.accuracy    <= i_cfg_wdata[ACC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: takes the request, forms vgs/vds, overdrive and clamped vds
    mccm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_drain_volt  (i_drain_volt),
        .i_source_volt (i_source_volt),
        .i_gate_volt   (i_gate_volt),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_q_item      (w_q_in)
    );

    // short queue so the front keeps taking requests while the back end works
    mccm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_item  (w_q_out),
        .o_empty (w_q_empty)
    );

    // back: square-law current, clamps, saturation, change filter, output slot
    mccm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_empty       (w_q_empty),
        .i_q_item        (w_q_out),
        .o_q_pop         (w_q_pop),
        .i_pop           (i_pop),
        .o_empty         (o_empty),
        .o_drain_current (o_drain_current)
    );

`ifndef SYNTH
    a_no_queue_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push && !w_q_pop |-> !w_q_full)
        else $error("front pushed into a full queue");

    a_no_queue_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("back end popped an empty queue");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("reset left a request or result behind");
`endif

endmodule

/* test/mosfet_channel_current_model_top_test.sv */
`timescale 1ns / 100ps

module mosfet_channel_current_model_top_test;
    import mccm_pkg::*;

    localparam int FRAC_BITS       = 16;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int MAX_GAP         = 5;
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 125;
    // receiver stall long enough to fill front stage and queue
    localparam int HOLD_CYCLES     = 300;
    // time for four requests in flight to drain through the back end
    localparam int SETTLE_CYCLES   = 80;
    // longest quiet stretch of a correct run is the receiver stall
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ONE_VOLT        = 1 << FRAC_BITS;
    localparam int BENCH_VOLTS     = 12 * ONE_VOLT;

    localparam logic [CFG_W-1:0]         CFG_MAX  = '1;
    localparam logic [ACC_W-1:0]         ACC_MAX  = '1;
    localparam logic signed [VOLT_W-1:0] VOLT_MAX = {1'b0, {(VOLT_W-1){1'b1}}};
    localparam logic signed [VOLT_W-1:0] VOLT_MIN = {1'b1, {(VOLT_W-1){1'b0}}};
    localparam longint                   CUR_MAX  = 64'sd2147483647;
    localparam longint                   CUR_MIN  = -64'sd2147483648;

    typedef struct packed {
        logic signed [VOLT_W-1:0] drain;
        logic signed [VOLT_W-1:0] source;
        logic signed [VOLT_W-1:0] gate;
    } t_node_volts;

    // square-law current predictor and store of expected drain currents
    class t_drain_current_scoreboard;
        bit                        p_channel;
        logic [CFG_W-1:0]          gate_offset;
        logic [CFG_W-1:0]          inv_resist;
        logic [CFG_W-1:0]          inv_k_rdson;
        logic [ACC_W-1:0]          accuracy;
        longint                    last_current;
        logic signed [CUR_W-1:0]   expected_currents[$];
        int                        mismatches;

        function new();
            p_channel    = CFG_RESET.p_channel;
            gate_offset  = CFG_RESET.gate_offset;
            inv_resist   = CFG_RESET.inv_resist;
            inv_k_rdson  = CFG_RESET.inv_k_rdson;
            accuracy     = CFG_RESET.accuracy;
            last_current = 0;
            mismatches   = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
            case (addr)
                CFG_P_CHANNEL:   p_channel   = data[0];
                CFG_GATE_OFFSET: gate_offset = data;
                CFG_INV_RESIST:  inv_resist  = data;
                CFG_INV_K_RDSON: inv_k_rdson = data;
                CFG_ACCURACY:    accuracy    = data[ACC_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(t_node_volts v);
            longint      vd, vs, vg, vgs, vds, ov, vc, sat_k, max_curr, term, x, ds, cur, diff;
            logic [63:0] ax;
            bit          ds_sat;
            bit          ds_pos;
            vd = v.drain;
            vs = v.source;
            vg = v.gate;
            ds_sat = 1'b0;
            ds_pos = 1'b0;
            // p-channel swaps the differences
            if (p_channel) begin
                vgs = vs - vg;
                vds = vs - vd;
            end else begin
                vgs = vg - vs;
                vds = vd - vs;
            end
            ov = vgs - longint'(gate_offset);
            if (ov < 0) begin
                ov = 0;
            end
            sat_k    = (longint'(1) << FRAC_BITS) + vds / 100;
            max_curr = (vds * longint'(inv_resist)) >>> FRAC_BITS;
            vc       = (vds > ov) ? ov : vds;
            term     = (ov * vc - ((vc * vc) >>> 1)) >>> FRAC_BITS;
            x        = (term * sat_k) >>> FRAC_BITS;
            ds       = 0;
            if (inv_k_rdson != 0 && x != 0) begin
                ax = (x < 0) ? -x : x;
                if (ax > (64'h4000_0000_0000_0000 / inv_k_rdson)) begin
                    ds_sat = 1'b1;
                    ds_pos = (x > 0);
                end else begin
                    ds = (x * longint'(inv_k_rdson)) >>> FRAC_BITS;
                end
            end
            if (ds_sat) begin
                cur = ds_pos ? 0 : CUR_MAX + 1;
            end else begin
                if (ds > max_curr) begin
                    ds = max_curr;
                end
                cur = max_curr - ds;
            end
            if (p_channel) begin
                cur = -cur;
            end
            if (cur > CUR_MAX) begin
                cur = CUR_MAX;
            end
            if (cur < CUR_MIN) begin
                cur = CUR_MIN;
            end
            // small changes are swallowed and leave the last current alone
            diff = cur - last_current;
            if (diff < 0) begin
                diff = -diff;
            end
            if (diff >= longint'(accuracy)) begin
                last_current = cur;
                expected_currents.push_back(cur[CUR_W-1:0]);
            end
        endfunction

        function void check_result(logic signed [CUR_W-1:0] got);
            logic signed [CUR_W-1:0] want;
            if (expected_currents.size() == 0) begin
                $error("drain_current: expected nothing, got %0d", got);
                mismatches++;
            end else begin
                want = expected_currents.pop_front();
                if (got !== want) begin
                    $error("drain_current: expected %0d, got %0d", want, got);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_currents.size();
        endfunction
    endclass

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0]    i_cfg_addr    = '0;
    logic [CFG_W-1:0]         i_cfg_wdata   = '0;
    logic                     i_push        = 1'b0;
    logic                     o_full;
    logic signed [VOLT_W-1:0] i_drain_volt  = '0;
    logic signed [VOLT_W-1:0] i_source_volt = '0;
    logic signed [VOLT_W-1:0] i_gate_volt   = '0;
    logic                     o_empty;
    logic                     i_pop         = 1'b0;
    logic signed [CUR_W-1:0]  o_drain_current;

    t_drain_current_scoreboard sb;
    t_node_volts               last_sent    = '0;
    bit                        idle_on      = 1'b1;
    bit                        hold_results = 1'b0;
    int                        idle_cycles  = 0;

    mosfet_channel_current_model_top #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_addr(i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_push(i_push),
        .o_full(o_full),
        .i_drain_volt(i_drain_volt),
        .i_source_volt(i_source_volt),
        .i_gate_volt(i_gate_volt),
        .o_empty(o_empty),
        .i_pop(i_pop),
        .o_drain_current(o_drain_current)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // handshakes are sampled mid-cycle, where nothing moves
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_push && !o_full) begin
                sb.note_request('{i_drain_volt, i_source_volt, i_gate_volt});
            end
            if (i_pop && !o_empty) begin
                sb.check_result(o_drain_current);
            end
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    // watchdog on a stretch with no request or result taken
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("mosfet_channel_current_model_top: mismatch");
        $finish;
    end

    // one request: optional gap, then hold until taken; returns on the taking edge
    task automatic push_request(input logic signed [VOLT_W-1:0] vd,
                                input logic signed [VOLT_W-1:0] vs,
                                input logic signed [VOLT_W-1:0] vg);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push        <= 1'b1;
        i_drain_volt  <= vd;
        i_source_volt <= vs;
        i_gate_volt   <= vg;
        last_sent     = '{vd, vs, vg};
        @(negedge i_clk);
        while (o_full) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // sender stops and waits for every expected current, then lets the pipe empty
    task automatic settle();
        i_push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        sb.set_reg(addr, data);
        @(posedge i_clk);
    endtask

    // all registers, junk in the unused upper bits, and writes to unmapped indexes
    task automatic load_config(input bit p, input logic [CFG_W-1:0] gate_off,
                               input logic [CFG_W-1:0] inv_res,
                               input logic [CFG_W-1:0] inv_k,
                               input logic [ACC_W-1:0] acc);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        write_reg(CFG_P_CHANNEL, {junk[CFG_W-1:1], p});
        write_reg(CFG_GATE_OFFSET, gate_off);
        write_reg(CFG_INV_RESIST, inv_res);
        write_reg(CFG_INV_K_RDSON, inv_k);
        write_reg(CFG_ACCURACY, {junk[CFG_W-1:ACC_W], acc});
        for (int a = int'(CFG_ACCURACY) + 1; a < (1 << CFG_ADDR_W); a++) begin
            write_reg(CFG_ADDR_W'(a), CFG_W'($urandom));
        end
        i_cfg_we <= 1'b0;
    endtask

    // either a value near the bench range or anything the register holds
    function automatic logic [CFG_W-1:0] pick_reg(int typical);
        return $urandom_range(0, 1) ? CFG_W'($urandom_range(0, typical))
                                    : CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
    endfunction

    function automatic logic signed [VOLT_W-1:0] corner_volt();
        case ($urandom_range(0, 4))
            0:       return VOLT_MAX;
            1:       return VOLT_MIN;
            2:       return '0;
            3:       return '1;
            default: return VOLT_W'(1);
        endcase
    endfunction

    function automatic logic signed [VOLT_W-1:0] bench_volt();
        return VOLT_W'(int'($urandom_range(0, 2 * BENCH_VOLTS)) - BENCH_VOLTS);
    endfunction

    // mix of full-range noise, bench voltages, repeats, tiny nudges and corners
    function automatic t_node_volts random_volts();
        t_node_volts v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = '{VOLT_W'($urandom), VOLT_W'($urandom), VOLT_W'($urandom)};
            3, 4, 5, 6: v = '{bench_volt(), bench_volt(), bench_volt()};
            7: v = last_sent;
            8: begin
                v = last_sent;
                v.drain = v.drain + VOLT_W'($urandom_range(0, 64)) - VOLT_W'(32);
            end
            default: v = '{corner_volt(), corner_volt(), corner_volt()};
        endcase
        return v;
    endfunction

    // hand-picked operating points: off, linear, saturated, reverse, rails
    task automatic run_corner_requests();
        push_request('0, '0, '0);
        push_request(VOLT_W'(ONE_VOLT), '0, VOLT_W'(5 * ONE_VOLT));
        push_request(VOLT_W'(8 * ONE_VOLT), '0, VOLT_W'(3 * ONE_VOLT));
        push_request(VOLT_W'(5 * ONE_VOLT), '0, VOLT_W'(ONE_VOLT));
        push_request(VOLT_W'(-2 * ONE_VOLT), '0, VOLT_W'(5 * ONE_VOLT));
        push_request(VOLT_W'(-2 * ONE_VOLT), '0, VOLT_W'(5 * ONE_VOLT));
        push_request(VOLT_MAX, VOLT_MIN, VOLT_MAX);
        push_request(VOLT_MIN, VOLT_MAX, VOLT_MIN);
        push_request(VOLT_MIN, VOLT_MAX, VOLT_MAX);
        push_request(VOLT_MAX, VOLT_MIN, VOLT_MIN);
        push_request('1, '0, '1);
        push_request('0, '0, '0);
    endtask

    // receiver: random pops, one long stall on request from the stimulus
    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_results) begin
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end
            gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_pop <= 1'b1;
            @(negedge i_clk);
            while (o_empty) @(negedge i_clk);
            @(posedge i_clk);
        end
    end

    initial begin
        t_node_volts v;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner points under the reset defaults, then under extreme p-channel settings
        run_corner_requests();
        settle();
        load_config(1'b1, '0, CFG_MAX, CFG_MAX, '0);
        idle_on = 1'b0;
        run_corner_requests();
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       load_config(1'b0, CFG_MAX, CFG_MAX, CFG_MAX, ACC_MAX);
                1:       load_config(1'b1, '0, '0, CFG_MAX, '0);
                2:       load_config(1'b0, CFG_MAX, CFG_MAX, '0, '0);
                default: load_config(1'($urandom_range(0, 1)), pick_reg(10 * ONE_VOLT),
                                     pick_reg(4 * ONE_VOLT), pick_reg(4 * ONE_VOLT),
                                     ($urandom_range(0, 3) == 0)
                                         ? ACC_W'($urandom_range(0, ACC_MAX))
                                         : ACC_W'($urandom_range(0, 2000)));
            endcase
            // some phases run back to back with no gaps on either side
            idle_on = (phase % 4) != 2;
            // stall the receiver while requests keep coming so the input backs up
            if (phase == 3) begin
                hold_results = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                v = random_volts();
                push_request(v.drain, v.source, v.gate);
            end
            settle();
        end

        if (sb.mismatches == 0) begin
            $display("mosfet_channel_current_model_top: match");
        end else begin
            $display("mosfet_channel_current_model_top: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
design/mccm_pkg.sv
design/mccm_front.sv
design/mccm_queue.sv
design/mccm_back.sv
design/mosfet_channel_current_model_top.sv
test/mosfet_channel_current_model_top_test.sv
